[hw/rtl/ctg_pkg.sv]
// Shared types, constants and helpers for the circle trajectory generator.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package ctg_pkg;

  // Stream and config port widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 304;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Internal datapath widths
  localparam int unsigned OMEGA_W = 19;  // Q16.16 rad/s, below 2^19
  localparam int unsigned SPEED_W = 34;  // R * omega >> 16
  localparam int unsigned ACCEL_W = 37;  // speed * omega >> 16
  localparam int unsigned CW      = 34;  // CORDIC x, y, z
  localparam int unsigned MAG_W   = 31;  // |sin|, |cos| in Q2.30
  localparam int unsigned VM_W    = 36;  // velocity magnitude
  localparam int unsigned AM_W    = 39;  // acceleration magnitude
  localparam int unsigned SAT_W   = 41;  // pre-saturation sums

  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic [30:0]          TWO_PI_Q28      = 31'd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] ANGLE_STEP [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  localparam logic [15:0] HD_TANGENT_OFS = 16'h4000;
  localparam logic [15:0] HD_CENTER_OFS  = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_TURN_RATE    = 3'd4,
    REG_HEADING_MODE = 3'd5,
    REG_TRACK_ID     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HM_TANGENT = 2'd0,
    HM_CENTER  = 2'd1,
    HM_ZERO    = 2'd2
  } heading_mode_e;

  // Rotation state plus magnitudes that ride along with it
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
    logic [SPEED_W-1:0]   speed;
    logic [ACCEL_W-1:0]   accel;
  } cordic_t;

  // Fields carried untouched to the output stage
  typedef struct packed {
    logic [OMEGA_W-1:0] omega;
    logic [15:0]        hd;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v[SAT_W-1:31] == '0 || v[SAT_W-1:31] == '1) begin
      return v[31:0];
    end else if (v[SAT_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

[hw/rtl/circle_trajectory_generator_core.sv]
// Circle trajectory generator core: elapsed time in, pose and rates out.
// One item per cycle sustained while the output is not stalled. Depth is set
// by the 16-stage CORDIC pipeline plus phase, fold, sign, multiply, combine
// and output stages. Reset (rst_ni low, async) restores register defaults
// and clears all stage valid bits.
`timescale 1ns / 1ps

module circle_trajectory_generator_core import ctg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [31:0] elapsed_time
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] vel_x,
  // [159:128] vel_y, [191:160] acc_x, [223:192] acc_y, [239:224] heading,
  // [271:240] heading_rate, [303:272] track_id_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned TB      = SINE_TABLE_BITS;
  localparam int unsigned NS      = CORDIC_STEPS + 6;
  localparam int unsigned ST_POST = CORDIC_STEPS + 2;
  localparam int unsigned ST_MULT = ST_POST + 1;
  localparam int unsigned ST_COMB = ST_POST + 2;

  // ---------------- configuration registers ----------------
  logic [31:0] cx_q, cy_q, cz_q, rate_q, id_q;
  logic [30:0] rad_q;
  logic [1:0]  mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= 32'd0;
      cy_q   <= 32'd0;
      cz_q   <= 32'd65536;
      rad_q  <= 31'd262144;
      rate_q <= 32'd214748365;
      mode_q <= HM_TANGENT;
      id_q   <= 32'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_X:     cx_q   <= cfg_data_i;
        REG_CENTER_Y:     cy_q   <= cfg_data_i;
        REG_CENTER_Z:     cz_q   <= cfg_data_i;
        REG_RADIUS:       rad_q  <= cfg_data_i[30:0];
        REG_TURN_RATE:    rate_q <= cfg_data_i;
        REG_HEADING_MODE: mode_q <= cfg_data_i[1:0];
        REG_TRACK_ID:     id_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage valid bits and flow control ----------------
  // A stage may load unless it and every stage after it are full and the
  // output is stalled, so bubbles collapse.
  logic [NS-1:0] vld_q, vld_d, en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = m_axis_tready_i | ~(&vld_q[NS-1:k]);
  end

  assign vld_d = {vld_q[NS-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NS-1];

  // ---------------- stage 0: phase and omega ----------------
  logic [63:0]   ph_prod;
  logic [62:0]   om_prod;
  logic [TB-1:0] ang_q;
  side_t         side_d0;
  side_t         side_q [NS-1];

  assign ph_prod       = s_axis_tdata_i * rate_q;
  assign om_prod       = rate_q * TWO_PI_Q28;
  assign side_d0.omega = om_prod[62:44];
  assign side_d0.hd    = ph_prod[47:32];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ang_q     <= ph_prod[47 -: TB];
      side_q[0] <= side_d0;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------- stage 1: fold to the half turn about zero ----------------
  cordic_t     cord_q [CORDIC_STEPS+1];
  cordic_t     fold_d;
  logic        flip0;
  logic [31:0] pfold;
  logic [49:0] spd_prod;

  always_comb begin
    // second and third quadrant: rotate by half a turn, negate at the end
    flip0        = ang_q[TB-1] ^ ang_q[TB-2];
    pfold        = {ang_q[TB-1] ^ flip0, ang_q[TB-2:0], {(32-TB){1'b0}}};
    spd_prod     = rad_q * side_q[0].omega;
    fold_d.x     = CORDIC_GAIN_Q30;
    fold_d.y     = '0;
    fold_d.z     = CW'($signed(pfold));
    fold_d.flip  = flip0;
    fold_d.speed = spd_prod[49:16];
    fold_d.accel = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) cord_q[0] <= fold_d;
  end

  // ---------------- stages 2..17: one CORDIC rotation each ----------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ANG = CW'(ANGLE_STEP[i]);
    cordic_t              step_d;
    logic signed [CW-1:0] dx, dy;
    logic [ACCEL_W-1:0]   accel;

    if (i == 0) begin : g_acc
      logic [52:0] acc_prod;
      assign acc_prod = cord_q[0].speed * side_q[1].omega;
      assign accel    = acc_prod[52:16];
    end else begin : g_pass
      assign accel = cord_q[i].accel;
    end

    always_comb begin
      dx           = $signed(cord_q[i].y) >>> i;
      dy           = $signed(cord_q[i].x) >>> i;
      step_d       = cord_q[i];
      step_d.accel = accel;
      if (!cord_q[i].z[CW-1]) begin
        step_d.x = cord_q[i].x - dx;
        step_d.y = cord_q[i].y + dy;
        step_d.z = cord_q[i].z - ANG;
      end else begin
        step_d.x = cord_q[i].x + dx;
        step_d.y = cord_q[i].y - dy;
        step_d.z = cord_q[i].z + ANG;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[2+i]) cord_q[i+1] <= step_d;
    end
  end

  // ---------------- stage 18: signs and magnitudes ----------------
  logic signed [CW-1:0] fx, fy, fxa, fya;
  logic [MAG_W-1:0]     cmag_q, smag_q;
  logic                 cneg_q, sneg_q;
  logic [SPEED_W-1:0]   spd_q;
  logic [ACCEL_W-1:0]   acc_q;

  always_comb begin
    fx  = cord_q[CORDIC_STEPS].x;
    fy  = cord_q[CORDIC_STEPS].y;
    fxa = fx[CW-1] ? -fx : fx;
    fya = fy[CW-1] ? -fy : fy;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_POST]) begin
      cmag_q <= fxa[MAG_W-1:0];
      smag_q <= fya[MAG_W-1:0];
      cneg_q <= fx[CW-1] ^ cord_q[CORDIC_STEPS].flip;
      sneg_q <= fy[CW-1] ^ cord_q[CORDIC_STEPS].flip;
      spd_q  <= cord_q[CORDIC_STEPS].speed;
      acc_q  <= cord_q[CORDIC_STEPS].accel;
    end
  end

  // ---------------- stage 19: partial products ----------------
  // Wide magnitudes split at bit 32; recombined as (hi << 2) + (lo >> 30).
  logic [61:0] pxl_q, pyl_q;
  logic [62:0] vxl_q, vyl_q, axl_q, ayl_q;
  logic [32:0] vxh_q, vyh_q;
  logic [35:0] axh_q, ayh_q;
  logic        cneg_m_q, sneg_m_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MULT]) begin
      pxl_q    <= rad_q * cmag_q;
      pyl_q    <= rad_q * smag_q;
      vxl_q    <= spd_q[31:0] * smag_q;
      vxh_q    <= spd_q[SPEED_W-1:32] * smag_q;
      vyl_q    <= spd_q[31:0] * cmag_q;
      vyh_q    <= spd_q[SPEED_W-1:32] * cmag_q;
      axl_q    <= acc_q[31:0] * cmag_q;
      axh_q    <= acc_q[ACCEL_W-1:32] * cmag_q;
      ayl_q    <= acc_q[31:0] * smag_q;
      ayh_q    <= acc_q[ACCEL_W-1:32] * smag_q;
      cneg_m_q <= cneg_q;
      sneg_m_q <= sneg_q;
    end
  end

  // ---------------- stage 20: magnitudes ----------------
  logic [31:0]     pxm_q, pym_q;
  logic [VM_W-1:0] vxm_q, vym_q;
  logic [AM_W-1:0] axm_q, aym_q;
  logic            cneg_c_q, sneg_c_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_COMB]) begin
      pxm_q    <= pxl_q[61:30];
      pym_q    <= pyl_q[61:30];
      vxm_q    <= VM_W'({vxh_q, 2'b00}) + VM_W'(vxl_q[62:30]);
      vym_q    <= VM_W'({vyh_q, 2'b00}) + VM_W'(vyl_q[62:30]);
      axm_q    <= AM_W'({axh_q, 2'b00}) + AM_W'(axl_q[62:30]);
      aym_q    <= AM_W'({ayh_q, 2'b00}) + AM_W'(ayl_q[62:30]);
      cneg_c_q <= cneg_m_q;
      sneg_c_q <= sneg_m_q;
    end
  end

  // ---------------- stage 21: signs, center, saturation ----------------
  logic signed [SAT_W-1:0] px_s, py_s, vx_s, vy_s, ax_s, ay_s;
  logic [15:0]             hd_d;
  logic [31:0]             hr_d;
  logic [OUT_TDATA_W-1:0]  out_d, out_q;

  always_comb begin
    px_s = cneg_c_q ? SAT_W'($signed(cx_q)) - SAT_W'(pxm_q)
                    : SAT_W'($signed(cx_q)) + SAT_W'(pxm_q);
    py_s = sneg_c_q ? SAT_W'($signed(cy_q)) - SAT_W'(pym_q)
                    : SAT_W'($signed(cy_q)) + SAT_W'(pym_q);
    // velocity x and both accelerations carry an extra minus sign
    vx_s = sneg_c_q ? SAT_W'(vxm_q) : SAT_W'(0) - SAT_W'(vxm_q);
    vy_s = cneg_c_q ? SAT_W'(0) - SAT_W'(vym_q) : SAT_W'(vym_q);
    ax_s = cneg_c_q ? SAT_W'(axm_q) : SAT_W'(0) - SAT_W'(axm_q);
    ay_s = sneg_c_q ? SAT_W'(aym_q) : SAT_W'(0) - SAT_W'(aym_q);
  end

  always_comb begin
    case (mode_q)
      HM_TANGENT: begin
        hd_d = side_q[ST_COMB].hd + HD_TANGENT_OFS;
        hr_d = 32'(side_q[ST_COMB].omega);
      end
      HM_CENTER: begin
        hd_d = side_q[ST_COMB].hd + HD_CENTER_OFS;
        hr_d = 32'(side_q[ST_COMB].omega);
      end
      HM_ZERO: begin
        hd_d = '0;
        hr_d = '0;
      end
      default: begin
        hd_d = '0;
        hr_d = '0;
      end
    endcase
  end

  assign out_d = {id_q, hr_d, hd_d, sat32(ay_s), sat32(ax_s), sat32(vy_s),
                  sat32(vx_s), cz_q, sat32(py_s), sat32(px_s)};

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) out_q <= out_d;
  end

  assign m_axis_tdata_o = out_q;

endmodule

[hw/rtl/ctg_checker.sv]
// Port-level checks for the circle trajectory generator core.
// Depends on ctg_pkg; bound to circle_trajectory_generator_core below.
`timescale 1ns / 1ps

module ctg_checker import ctg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // stalled result item holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o);
  endproperty

  // input side may only stall when the output register is stuck
  property p_ready_free;
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o || m_axis_tready_i |-> s_axis_tready_o;
  endproperty

  // no result item can appear right out of reset
  property p_reset_empty;
    @(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o;
  endproperty

  a_out_hold: assert property (p_out_hold)
    else $error("result item changed while stalled");
  a_ready_free: assert property (p_ready_free)
    else $error("input stalled with free output");
  a_reset_empty: assert property (p_reset_empty)
    else $error("result item valid after reset");

endmodule

bind circle_trajectory_generator_core ctg_checker u_ctg_checker (.*);

[dv/circle_trajectory_generator_checker.sv]
// Scoreboard for the circle trajectory generator: mirrors the register file,
// predicts one pose per accepted time item and compares every output item.
// Depends on ctg_pkg for port widths, register indexes and heading modes.
`timescale 1ns / 1ps

module circle_trajectory_generator_checker import ctg_pkg::*; #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     checked_o
);

  localparam int ROT_STEPS = 16;
  localparam longint ROT_GAIN_Q30 = 64'sd652032874;
  localparam logic [63:0] TWO_PI_Q3_28 = 64'd1686629713;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] HALF_TURN    = 16'h8000;

  // atan(2^-i) as a fraction of a turn, Q0.32
  localparam logic [31:0] ATAN_TURNS [ROT_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Field order follows the output tdata, pos_x in the lowest bits
  typedef struct packed {
    logic [31:0] track;
    logic [31:0] hd_rate;
    logic [15:0] hd;
    logic [31:0] acc_y;
    logic [31:0] acc_x;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  logic [31:0] ctr_x, ctr_y, ctr_z, rate, track;
  logic [30:0] radius;
  logic [1:0]  hmode;
  pose_t       due_poses [$];
  pose_t       want, got;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > S32_MAX) return 32'h7FFF_FFFF;
    if (v < S32_MIN) return 32'h8000_0000;
    return 32'(v);
  endfunction

  // magnitude times a Q2.30 sine or cosine, truncated toward zero
  function automatic longint mul_q30(input logic [63:0] mag, input longint c);
    logic [127:0] prod;
    logic [63:0]  a;
    longint       r;
    a = (c < 0) ? 64'(-c) : 64'(c);
    prod = {64'd0, mag} * {64'd0, a};
    r = longint'(prod[93:30]);
    return (c < 0) ? -r : r;
  endfunction

  function automatic void unit_circle(input logic [31:0] phase, output longint sn,
                                      output longint cs);
    logic [31:0] p;
    logic        flip;
    longint      x, y, z, dx, dy;
    p = phase & ~((32'd1 << (32 - TABLE_BITS)) - 32'd1);
    // fold the second and third quadrants onto the half turn about zero, negate at the end
    flip = (p[31:30] == 2'b01) || (p[31:30] == 2'b10);
    if (flip) p = p ^ 32'h8000_0000;
    x = ROT_GAIN_Q30;
    y = 0;
    z = longint'($signed(p));
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURNS[i]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic pose_t predict_pose(input logic [31:0] t);
    logic [63:0] wide, omega, speed, accel;
    logic [31:0] phase;
    longint      sn, cs;
    pose_t       p;
    wide  = {32'd0, t} * {32'd0, rate};
    phase = wide[47:16];
    wide  = {32'd0, rate} * TWO_PI_Q3_28;
    omega = wide >> 44;
    speed = ({33'd0, radius} * omega) >> 16;
    accel = (speed * omega) >> 16;
    unit_circle(phase, sn, cs);
    p.pos_x   = clamp32(longint'($signed(ctr_x)) + mul_q30({33'd0, radius}, cs));
    p.pos_y   = clamp32(longint'($signed(ctr_y)) + mul_q30({33'd0, radius}, sn));
    p.pos_z   = ctr_z;
    p.vel_x   = clamp32(-mul_q30(speed, sn));
    p.vel_y   = clamp32(mul_q30(speed, cs));
    p.acc_x   = clamp32(-mul_q30(accel, cs));
    p.acc_y   = clamp32(-mul_q30(accel, sn));
    p.hd      = '0;
    p.hd_rate = '0;
    p.track   = track;
    if (hmode == HM_TANGENT) begin
      p.hd      = phase[31:16] + QUARTER_TURN;
      p.hd_rate = omega[31:0];
    end else if (hmode == HM_CENTER) begin
      p.hd      = phase[31:16] + HALF_TURN;
      p.hd_rate = omega[31:0];
    end
    return p;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x  <= '0;
      ctr_y  <= '0;
      ctr_z  <= 32'd65536;
      radius <= 31'd262144;
      rate   <= 32'd214748365;
      hmode  <= HM_TANGENT;
      track  <= 32'd1;
      due_poses.delete();
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = pose_t'(m_tdata_i);
        if (due_poses.size() == 0) begin
          errors_o++;
          $display("%0t: output item with no pose expected, got %h", $time, m_tdata_i);
        end else begin
          want = due_poses.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("pos_z", want.pos_z, got.pos_z);
          check_field("vel_x", want.vel_x, got.vel_x);
          check_field("vel_y", want.vel_y, got.vel_y);
          check_field("acc_x", want.acc_x, got.acc_x);
          check_field("acc_y", want.acc_y, got.acc_y);
          check_field("heading", {16'd0, want.hd}, {16'd0, got.hd});
          check_field("heading_rate", want.hd_rate, got.hd_rate);
          check_field("track_id_out", want.track, got.track);
          checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CENTER_X:     ctr_x  = cfg_data_i;
          REG_CENTER_Y:     ctr_y  = cfg_data_i;
          REG_CENTER_Z:     ctr_z  = cfg_data_i;
          REG_RADIUS:       radius = cfg_data_i[30:0];
          REG_TURN_RATE:    rate   = cfg_data_i;
          REG_HEADING_MODE: hmode  = cfg_data_i[1:0];
          REG_TRACK_ID:     track  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) due_poses.push_back(predict_pose(s_tdata_i));
      pending_o <= due_poses.size();
    end
  end

endmodule

[dv/circle_trajectory_generator_core_test.sv]
// Top of the circle trajectory generator test: clock, reset, register setups,
// bursty time stimulus, output back-pressure, watchdog and verdict.
// Depends on ctg_pkg, the core and circle_trajectory_generator_checker.
`timescale 1ns / 1ps

module circle_trajectory_generator_core_test;
  import ctg_pkg::*;

  localparam int unsigned TABLE_BITS = 10;
  localparam int LATENCY         = 22;
  localparam int STALL_LIMIT     = 1000;
  localparam int RANDOM_SETUPS   = 6;
  localparam int ITEMS_PER_SETUP = 122;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [1:0] HM_SPARE = 2'd3;

  typedef enum {RX_FLOW, RX_TOGGLE, RX_RANDOM, RX_CHOKE} rx_pattern_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors, pending, checked;
  int burst_left = 0;
  int items_sent = 0;
  int setups = 0;
  int idle_cycles = 0;

  circle_trajectory_generator_core #(.SINE_TABLE_BITS(TABLE_BITS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  circle_trajectory_generator_checker #(.TABLE_BITS(TABLE_BITS)) scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // bursts of random length, random gaps with junk on tdata in between
  task automatic send_time(input logic [31:0] t);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    items_sent++;
  endtask

  // pipeline empty: every pose back and the tail of the datapath flushed
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    setups++;
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    v = $urandom_range(0, 32'h001F_FFFF);
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1) ? v : -v;
    endcase
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 15))
      0:       return 32'h0;
      1, 2:    return 32'h7FFF_FFFF;
      3, 4, 5: return $urandom;
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1;
      3, 4, 5: return $urandom;
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32'h0010_0000);
    return $urandom;
  endfunction

  initial begin
    rx_pattern_e pat;
    int          len;
    forever begin
      pat = rx_pattern_e'($urandom_range(0, 3));
      len = $urandom_range(8, 60);
      repeat (len) begin
        @(negedge clk_i);
        case (pat)
          RX_FLOW:   m_tready <= 1'b1;
          RX_TOGGLE: m_tready <= !m_tready;
          RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
          default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, points spread over the four quadrants
    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0001_0000);
    send_time(32'h0005_0000);
    send_time(32'h000A_0000);
    send_time(32'h000F_0000);
    settle();

    // extremes everywhere, large products saturate
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Z, 32'h8000_0000);
    write_reg(REG_RADIUS, 32'h7FFF_FFFF);
    write_reg(REG_TURN_RATE, 32'hFFFF_FFFF);
    write_reg(REG_HEADING_MODE, 32'h0000_0000 | HM_CENTER);
    write_reg(REG_TRACK_ID, 32'hFFFF_FFFF);
    send_time(32'h0000_0000);
    send_time(32'h0000_0001);
    send_time(32'hFFFF_FFFF);
    send_time(32'h8000_0000);
    settle();

    // zero radius via a dropped top bit, zero rate, unused mode, spare index
    write_reg(REG_RADIUS, 32'h8000_0000);
    write_reg(REG_TURN_RATE, 32'h0);
    write_reg(REG_HEADING_MODE, 32'hFFFF_FFFC | HM_SPARE);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);
    send_time(32'h1234_5678);
    settle();

    // smallest nonzero radius and rate, fixed heading with junk high bits
    write_reg(REG_CENTER_X, 32'h0);
    write_reg(REG_CENTER_Y, 32'h0);
    write_reg(REG_RADIUS, 32'h1);
    write_reg(REG_TURN_RATE, 32'h1);
    write_reg(REG_HEADING_MODE, 32'hFFFF_FFFC | HM_ZERO);
    write_reg(REG_TRACK_ID, 32'h0);
    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);
    settle();

    // quarter turn per second, tangent heading
    write_reg(REG_RADIUS, 32'h0010_0000);
    write_reg(REG_TURN_RATE, 32'h4000_0000);
    write_reg(REG_HEADING_MODE, 32'h0000_0000 | HM_TANGENT);
    for (int s = 0; s < 4; s++) send_time(32'h0001_0000 * s);
    settle();

    for (int k = 0; k < RANDOM_SETUPS; k++) begin
      write_reg(REG_CENTER_X, pick_coord());
      write_reg(REG_CENTER_Y, pick_coord());
      write_reg(REG_CENTER_Z, pick_coord());
      write_reg(REG_RADIUS, pick_radius());
      write_reg(REG_TURN_RATE, pick_rate());
      write_reg(REG_HEADING_MODE, ($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3));
      write_reg(REG_TRACK_ID, $urandom);
      for (int n = 0; n < ITEMS_PER_SETUP; n++) send_time(pick_time());
      settle();
    end

    $display("Sent %0d time items over %0d register setups, %0d poses compared.",
             items_sent, setups, checked);
    $display("Setups spanned saturation, zero radius, zero rate and all heading modes.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
